### src/gbgs_pkg.sv
// Shared types and codes for the gap buffer with group search.
// Used by gbgs_ram, gbgs_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps

package gbgs_pkg;

    // Defaults for the top-level parameters
    localparam int CAPACITY_DEF    = 1024;
    localparam int SYMBOL_BITS_DEF = 10;

    localparam int ACTION_BITS = 3;
    localparam int KIND_BITS   = 2;

    // Command codes
    localparam logic [ACTION_BITS-1:0] ACT_INSERT     = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_DELETE     = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_READ       = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_ERASE      = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_FIND_END   = 3'd4;
    localparam logic [ACTION_BITS-1:0] ACT_FIND_BEGIN = 3'd5;

    // Entry kinds
    localparam logic [KIND_BITS-1:0] KIND_OTHER = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_BEGIN = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_END   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_RANGE     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_READ,
        S_SCAN
    } t_state;

    // Memory port strobes from the controller
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

### src/gbgs_ram.sv
// Entry store: simple dual-port RAM, one write and one registered read per cycle.
// Depends on gbgs_pkg for the port strobe struct.
`timescale 1ns / 1ps

module gbgs_ram #(
    parameter int DEPTH = gbgs_pkg::CAPACITY_DEF,
    parameter int WIDTH = gbgs_pkg::SYMBOL_BITS_DEF + gbgs_pkg::KIND_BITS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  gbgs_pkg::t_mem_ctl  i_ctl,
    input  logic [AW-1:0]       i_waddr,
    input  logic [WIDTH-1:0]    i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output logic [WIDTH-1:0]    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/gbgs_ctrl.sv
// Command sequencer: gap bookkeeping, pipelined gap moves and group scans.
// Depends on gbgs_pkg; drives the port of gbgs_ram.
`timescale 1ns / 1ps

module gbgs_ctrl #(
    parameter int CAPACITY    = gbgs_pkg::CAPACITY_DEF,
    parameter int SYMBOL_BITS = gbgs_pkg::SYMBOL_BITS_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int EW = SYMBOL_BITS + gbgs_pkg::KIND_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [gbgs_pkg::ACTION_BITS-1:0]  i_action,
    input  logic [CW-1:0]                     i_position,
    input  logic [SYMBOL_BITS-1:0]            i_symbol_code,
    input  logic [gbgs_pkg::KIND_BITS-1:0]    i_entry_kind,
    output gbgs_pkg::t_mem_ctl                o_mem_ctl,
    output logic [AW-1:0]                     o_mem_waddr,
    output logic [EW-1:0]                     o_mem_wdata,
    output logic [AW-1:0]                     o_mem_raddr,
    input  logic [EW-1:0]                     i_mem_rdata,
    output logic                              o_strobe,
    output logic [SYMBOL_BITS-1:0]            o_read_symbol,
    output logic [gbgs_pkg::KIND_BITS-1:0]    o_read_kind,
    output logic [AW-1:0]                     o_found_position,
    output gbgs_pkg::t_status                 o_status,
    output logic [CW-1:0]                     o_entry_count
);

    gbgs_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_front, n_front;
    logic [CW-1:0]     r_back,  n_back;
    logic [CW-1:0]     r_gap,   n_gap;
    logic [gbgs_pkg::ACTION_BITS-1:0] r_act, n_act;
    logic [CW-1:0]     r_pos,   n_pos;     // gap move target
    logic [EW-1:0]     r_entry, n_entry;   // entry waiting to be inserted
    logic              r_left,  n_left;    // move or scan runs toward index zero
    logic [CW-1:0]     r_src,   n_src;     // next address (move) or index (scan)
    logic [CW-1:0]     r_cnt,   n_cnt;     // reads still to issue
    logic              r_pend_vld, n_pend_vld;
    logic [CW-1:0]     r_pend,  n_pend;    // address or index of data now on rdata
    logic [CW-1:0]     r_depth, n_depth;
    logic              r_strobe, n_strobe;
    logic [SYMBOL_BITS-1:0]         r_rsym,  n_rsym;
    logic [gbgs_pkg::KIND_BITS-1:0] r_rkind, n_rkind;
    logic [AW-1:0]     r_found, n_found;
    gbgs_pkg::t_status r_status, n_status;

    logic [CW-1:0]     size_now;
    logic [CW-1:0]     ins_pos;
    logic [gbgs_pkg::KIND_BITS-1:0] ins_kind;
    logic [CW-1:0]     pos_phys;
    logic [CW-1:0]     src_phys;
    logic [CW-1:0]     move_dst;
    logic [CW-1:0]     moved_back;
    logic [gbgs_pkg::KIND_BITS-1:0] rd_kind;
    logic [gbgs_pkg::KIND_BITS-1:0] open_kind;
    logic [gbgs_pkg::KIND_BITS-1:0] close_kind;

    assign size_now   = r_front + r_back;
    assign ins_pos    = (i_position > size_now) ? size_now : i_position;
    assign ins_kind   = (i_entry_kind == gbgs_pkg::KIND_SPARE) ? gbgs_pkg::KIND_OTHER
                                                                : i_entry_kind;
    assign pos_phys   = (i_position < r_front) ? i_position : i_position + r_gap;
    assign src_phys   = (r_src < r_front) ? r_src : r_src + r_gap;
    assign move_dst   = r_left ? (r_pend + r_gap) : (r_pend - r_gap);
    assign moved_back = r_back + r_front - r_pos;
    assign rd_kind    = i_mem_rdata[EW-1 -: gbgs_pkg::KIND_BITS];
    // searching forward a begin nests, an end closes; backward the other way
    assign open_kind  = r_left ? gbgs_pkg::KIND_END   : gbgs_pkg::KIND_BEGIN;
    assign close_kind = r_left ? gbgs_pkg::KIND_BEGIN : gbgs_pkg::KIND_END;

    always_comb begin
        n_state    = r_state;
        n_front    = r_front;
        n_back     = r_back;
        n_gap      = r_gap;
        n_act      = r_act;
        n_pos      = r_pos;
        n_entry    = r_entry;
        n_left     = r_left;
        n_src      = r_src;
        n_cnt      = r_cnt;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_depth    = r_depth;
        n_strobe   = 1'b0;
        n_rsym     = r_rsym;
        n_rkind    = r_rkind;
        n_found    = r_found;
        n_status   = r_status;
        o_mem_ctl   = '0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_raddr = '0;

        unique case (r_state)
            gbgs_pkg::S_IDLE: begin
                if (i_start) begin
                    // most commands answer at once with empty payload
                    n_rsym     = '0;
                    n_rkind    = '0;
                    n_found    = '0;
                    n_status   = gbgs_pkg::STAT_OK;
                    n_strobe   = 1'b1;
                    n_act      = i_action;
                    n_pend_vld = 1'b0;
                    n_depth    = '0;
                    unique case (i_action)
                        gbgs_pkg::ACT_INSERT: begin
                            n_entry = {ins_kind, i_symbol_code};
                            if (r_gap == '0) begin
                                n_status = gbgs_pkg::STAT_FULL;
                            end else if (r_front == ins_pos) begin
                                o_mem_ctl.wr_en = 1'b1;
                                o_mem_waddr     = ins_pos[AW-1:0];
                                o_mem_wdata     = {ins_kind, i_symbol_code};
                                n_front         = r_front + 1'b1;
                                n_gap           = r_gap - 1'b1;
                            end else begin
                                n_strobe = 1'b0;
                                n_pos    = ins_pos;
                                n_left   = (r_front > ins_pos);
                                n_src    = (r_front > ins_pos) ? r_front - 1'b1
                                                               : r_front + r_gap;
                                n_cnt    = (r_front > ins_pos) ? r_front - ins_pos
                                                               : ins_pos - r_front;
                                n_state  = gbgs_pkg::S_MOVE;
                            end
                        end
                        gbgs_pkg::ACT_DELETE: begin
                            if (i_position >= size_now) begin
                                n_status = gbgs_pkg::STAT_RANGE;
                            end else if (i_position + 1'b1 == r_front) begin
                                n_front = r_front - 1'b1;
                                n_gap   = r_gap + 1'b1;
                            end else if (i_position == r_front) begin
                                n_back = r_back - 1'b1;
                                n_gap  = r_gap + 1'b1;
                            end else begin
                                n_strobe = 1'b0;
                                n_pos    = i_position;
                                n_left   = (r_front > i_position);
                                n_src    = (r_front > i_position) ? r_front - 1'b1
                                                                  : r_front + r_gap;
                                n_cnt    = (r_front > i_position) ? r_front - i_position
                                                                  : i_position - r_front;
                                n_state  = gbgs_pkg::S_MOVE;
                            end
                        end
                        gbgs_pkg::ACT_READ: begin
                            if (i_position >= size_now) begin
                                n_status = gbgs_pkg::STAT_RANGE;
                            end else begin
                                n_strobe        = 1'b0;
                                o_mem_ctl.rd_en = 1'b1;
                                o_mem_raddr     = pos_phys[AW-1:0];
                                n_state         = gbgs_pkg::S_READ;
                            end
                        end
                        gbgs_pkg::ACT_ERASE: begin
                            n_front = '0;
                            n_back  = '0;
                            n_gap   = CW'(CAPACITY);
                        end
                        gbgs_pkg::ACT_FIND_END: begin
                            if (i_position > size_now) begin
                                n_status = gbgs_pkg::STAT_RANGE;
                            end else if (i_position == size_now) begin
                                n_status = gbgs_pkg::STAT_NOT_FOUND;
                            end else begin
                                n_strobe = 1'b0;
                                n_left   = 1'b0;
                                n_src    = i_position;
                                n_cnt    = size_now - i_position;
                                n_state  = gbgs_pkg::S_SCAN;
                            end
                        end
                        gbgs_pkg::ACT_FIND_BEGIN: begin
                            if (i_position > size_now) begin
                                n_status = gbgs_pkg::STAT_RANGE;
                            end else if (i_position == '0) begin
                                n_status = gbgs_pkg::STAT_NOT_FOUND;
                            end else begin
                                n_strobe = 1'b0;
                                n_left   = 1'b1;
                                n_src    = i_position - 1'b1;
                                n_cnt    = i_position;
                                n_state  = gbgs_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            // unused codes: no change, plain ok
                        end
                    endcase
                end
            end

            gbgs_pkg::S_MOVE: begin
                // read one entry a cycle, write it across the gap in the next cycle
                if (r_cnt != '0) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_mem_raddr     = r_src[AW-1:0];
                    n_pend          = r_src;
                    n_pend_vld      = 1'b1;
                    n_src           = r_left ? r_src - 1'b1 : r_src + 1'b1;
                    n_cnt           = r_cnt - 1'b1;
                end else begin
                    n_pend_vld = 1'b0;
                end
                if (r_pend_vld) begin
                    o_mem_ctl.wr_en = 1'b1;
                    o_mem_waddr     = move_dst[AW-1:0];
                    o_mem_wdata     = i_mem_rdata;
                end else if (r_cnt == '0) begin
                    // gap now starts at r_pos: finish the edit
                    n_strobe = 1'b1;
                    n_state  = gbgs_pkg::S_IDLE;
                    if (r_act == gbgs_pkg::ACT_INSERT) begin
                        o_mem_ctl.wr_en = 1'b1;
                        o_mem_waddr     = r_pos[AW-1:0];
                        o_mem_wdata     = r_entry;
                        n_front         = r_pos + 1'b1;
                        n_back          = moved_back;
                        n_gap           = r_gap - 1'b1;
                    end else begin
                        n_front = r_pos;
                        n_back  = moved_back - 1'b1;
                        n_gap   = r_gap + 1'b1;
                    end
                end
            end

            gbgs_pkg::S_READ: begin
                n_rsym   = i_mem_rdata[SYMBOL_BITS-1:0];
                n_rkind  = rd_kind;
                n_strobe = 1'b1;
                n_state  = gbgs_pkg::S_IDLE;
            end

            gbgs_pkg::S_SCAN: begin
                if (r_cnt != '0) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_mem_raddr     = src_phys[AW-1:0];
                    n_pend          = r_src;
                    n_pend_vld      = 1'b1;
                    n_src           = r_left ? r_src - 1'b1 : r_src + 1'b1;
                    n_cnt           = r_cnt - 1'b1;
                end else begin
                    n_pend_vld = 1'b0;
                end
                if (r_pend_vld) begin
                    if (rd_kind == close_kind) begin
                        if (r_depth == '0) begin
                            // read issued this cycle is simply dropped
                            n_found    = r_pend[AW-1:0];
                            n_status   = gbgs_pkg::STAT_OK;
                            n_strobe   = 1'b1;
                            n_pend_vld = 1'b0;
                            n_state    = gbgs_pkg::S_IDLE;
                        end else begin
                            n_depth = r_depth - 1'b1;
                        end
                    end else if (rd_kind == open_kind) begin
                        n_depth = r_depth + 1'b1;
                    end
                end else if (r_cnt == '0) begin
                    n_status = gbgs_pkg::STAT_NOT_FOUND;
                    n_strobe = 1'b1;
                    n_state  = gbgs_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = gbgs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gbgs_pkg::S_IDLE;
            r_front    <= '0;
            r_back     <= '0;
            r_gap      <= CW'(CAPACITY);
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_front    <= n_front;
            r_back     <= n_back;
            r_gap      <= n_gap;
            r_pend_vld <= n_pend_vld;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_pos    <= n_pos;
        r_entry  <= n_entry;
        r_left   <= n_left;
        r_src    <= n_src;
        r_cnt    <= n_cnt;
        r_pend   <= n_pend;
        r_depth  <= n_depth;
        r_rsym   <= n_rsym;
        r_rkind  <= n_rkind;
        r_found  <= n_found;
        r_status <= n_status;
    end

    assign o_busy           = (r_state != gbgs_pkg::S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_read_symbol    = r_rsym;
    assign o_read_kind      = r_rkind;
    assign o_found_position = r_found;
    assign o_status         = r_status;
    assign o_entry_count    = size_now;

endmodule

### src/gap_buffer_with_group_search_unit.sv
// Gap buffer of token entries with nested group search; top level over gbgs_ctrl and gbgs_ram.
// Erase, errors and edits at the gap are answered from idle without raising busy; a read,
// an edit that moves the gap and a group scan run in the sequencer first.
// One transaction at a time: busy is high while a move, read or scan runs; the next is
// taken at the edge that takes the result, so commands answered from idle run back to back.
// Reset (i_rst_n, synchronous, active low) empties the buffer at once; RAM is not cleared.
`timescale 1ns / 1ps

module gap_buffer_with_group_search_unit #(
    parameter int CAPACITY    = gbgs_pkg::CAPACITY_DEF,
    parameter int SYMBOL_BITS = gbgs_pkg::SYMBOL_BITS_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int EW = SYMBOL_BITS + gbgs_pkg::KIND_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic [gbgs_pkg::ACTION_BITS-1:0] i_action,
    input  logic [CW-1:0]                    i_position,
    input  logic [SYMBOL_BITS-1:0]           i_symbol_code,
    input  logic [gbgs_pkg::KIND_BITS-1:0]   i_entry_kind,
    // result channel, valid for exactly the o_strobe cycle
    output logic                             o_strobe,
    output logic [SYMBOL_BITS-1:0]           o_read_symbol,
    output logic [gbgs_pkg::KIND_BITS-1:0]   o_read_kind,
    output logic [AW-1:0]                    o_found_position,
    output logic [1:0]                       o_status,
    output logic [CW-1:0]                    o_entry_count
);

    // Storage layout: physical words [0, front) hold the entries before the
    // gap, then gap free words, then back entries up to the top of the RAM.
    // Logical index n maps to n when n < front, else to n + gap.
    //
    // Gap moves stream through the single read port: the read for one entry
    // overlaps the write of the previous one. Moving down, reads walk down
    // below the gap while writes land above it; moving up, the reverse. So a
    // pending write never targets a word still to be read, and no forwarding
    // path is needed. The insert write happens in the cycle after the last move
    // write, keeping one write per cycle.
    //
    // Group scans keep a nesting depth: scanning forward, a group begin nests
    // and a group end at depth zero is the answer; scanning backward the roles
    // swap. Reads run one ahead of the depth check; a read issued in the cycle
    // the answer is found is discarded.

    gbgs_pkg::t_mem_ctl w_mem_ctl;
    logic [AW-1:0]      w_mem_waddr;
    logic [EW-1:0]      w_mem_wdata;
    logic [AW-1:0]      w_mem_raddr;
    logic [EW-1:0]      w_mem_rdata;

    gbgs_ctrl #(
        .CAPACITY    (CAPACITY),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_action         (i_action),
        .i_position       (i_position),
        .i_symbol_code    (i_symbol_code),
        .i_entry_kind     (i_entry_kind),
        .o_mem_ctl        (w_mem_ctl),
        .o_mem_waddr      (w_mem_waddr),
        .o_mem_wdata      (w_mem_wdata),
        .o_mem_raddr      (w_mem_raddr),
        .i_mem_rdata      (w_mem_rdata),
        .o_strobe         (o_strobe),
        .o_read_symbol    (o_read_symbol),
        .o_read_kind      (o_read_kind),
        .o_found_position (o_found_position),
        .o_status         (o_status),
        .o_entry_count    (o_entry_count)
    );

    // entry word: kind in the top two bits, symbol code below
    gbgs_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

`ifndef NO_ASSERTIONS
    // a result only appears once the sequencer is back in idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // every accepted transaction either answers next cycle or occupies the sequencer
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("accepted transaction dropped");

    // the RAM is written only by a running move or by an insert being accepted
    a_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_ctl.wr_en |-> (busy || start))
        else $error("RAM write outside a transaction");

    // store full is reported only when every word holds an entry
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == gbgs_pkg::STAT_FULL)) |-> (o_entry_count == CW'(CAPACITY)))
        else $error("store full reported below capacity");
`endif

endmodule

### dv/tb_top.sv
// Self-checking testbench for gap_buffer_with_group_search_unit.
// Depends on gbgs_pkg (codes, t_status) and the RTL under src/; reads no files.
`timescale 1ns / 1ps

module tb_top;
    import gbgs_pkg::*;

    // Block configuration under test
    localparam int TOKEN_CAP = 1024;
    localparam int SYM_W     = 10;
    localparam int ADR_W     = 10;
    localparam int CNT_W     = 11;

    // Action codes the block decodes as no-ops
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_7 = 3'd7;

    localparam logic [CNT_W-1:0] POS_MAX = '1;

    // Cycles without any transaction before the run is declared hung. The worst
    // legal wait is a full-store gap move plus a sender gap.
    localparam int STALL_LIMIT = 6000;
    // Quiet time after the last result, to catch stray strobes
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [SYM_W-1:0]     sym;
    } t_token;

    typedef struct packed {
        logic [SYM_W-1:0]     sym;
        logic [KIND_BITS-1:0] kind;
        logic [ADR_W-1:0]     found;
        t_status              status;
        logic [CNT_W-1:0]     count;
    } t_outcome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [ACTION_BITS-1:0] i_action = '0;
    logic [CNT_W-1:0]       i_position = '0;
    logic [SYM_W-1:0]       i_symbol_code = '0;
    logic [KIND_BITS-1:0]   i_entry_kind = '0;
    logic                   o_strobe;
    logic [SYM_W-1:0]       o_read_symbol;
    logic [KIND_BITS-1:0]   o_read_kind;
    logic [ADR_W-1:0]       o_found_position;
    logic [1:0]             o_status;
    logic [CNT_W-1:0]       o_entry_count;

    // Logical contents of the buffer, index 0 first; the gap is not modeled
    // since nothing visible depends on where it sits.
    t_token   token_seq[$];
    // Outcomes predicted for accepted transactions, oldest first
    t_outcome pending_results[$];

    int mismatch_count = 0;
    int stall_cycles = 0;
    int sender_idle_pct = 0;

    gap_buffer_with_group_search_unit #(
        .CAPACITY    (TOKEN_CAP),
        .SYMBOL_BITS (SYM_W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_position       (i_position),
        .i_symbol_code    (i_symbol_code),
        .i_entry_kind     (i_entry_kind),
        .o_strobe         (o_strobe),
        .o_read_symbol    (o_read_symbol),
        .o_read_kind      (o_read_kind),
        .o_found_position (o_found_position),
        .o_status         (o_status),
        .o_entry_count    (o_entry_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Applies one command to the logical token sequence and returns what the
    // block must report for it.
    function automatic t_outcome predict_outcome(
        input logic [ACTION_BITS-1:0] act,
        input logic [CNT_W-1:0]       pos,
        input logic [SYM_W-1:0]       sym,
        input logic [KIND_BITS-1:0]   kind
    );
        t_outcome r;
        t_token   tok;
        int       p;
        int       n;
        int       j;
        int       depth;
        bit       done;
        r.sym    = '0;
        r.kind   = '0;
        r.found  = '0;
        r.status = STAT_OK;
        p        = pos;
        n        = token_seq.size();
        depth    = 0;
        done     = 1'b0;
        case (act)
            ACT_INSERT: begin
                if (p > n) p = n;       // insert past the end appends
                if (n == TOKEN_CAP) begin
                    r.status = STAT_FULL;
                end else begin
                    tok.kind = (kind == KIND_SPARE) ? KIND_OTHER : kind;
                    tok.sym  = sym;
                    token_seq.insert(p, tok);
                end
            end
            ACT_DELETE: begin
                if (p >= n) r.status = STAT_RANGE;
                else token_seq.delete(p);
            end
            ACT_READ: begin
                if (p >= n) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.sym  = token_seq[p].sym;
                    r.kind = token_seq[p].kind;
                end
            end
            ACT_ERASE: token_seq.delete();
            ACT_FIND_END: begin
                // forward walk; a nested begin must be closed before ours counts
                if (p > n) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.status = STAT_NOT_FOUND;
                    for (j = p; j < n && !done; j++) begin
                        if (token_seq[j].kind == KIND_BEGIN) begin
                            depth++;
                        end else if (token_seq[j].kind == KIND_END) begin
                            if (depth == 0) begin
                                r.found  = ADR_W'(j);
                                r.status = STAT_OK;
                                done     = 1'b1;
                            end else begin
                                depth--;
                            end
                        end
                    end
                end
            end
            ACT_FIND_BEGIN: begin
                // backward walk starting just below the position
                if (p > n) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.status = STAT_NOT_FOUND;
                    for (j = p; j > 0 && !done; j--) begin
                        if (token_seq[j-1].kind == KIND_END) begin
                            depth++;
                        end else if (token_seq[j-1].kind == KIND_BEGIN) begin
                            if (depth == 0) begin
                                r.found  = ADR_W'(j - 1);
                                r.status = STAT_OK;
                                done     = 1'b1;
                            end else begin
                                depth--;
                            end
                        end
                    end
                end
            end
            default: ;  // spare codes change nothing
        endcase
        r.count = CNT_W'(token_seq.size());
        return r;
    endfunction

    // Presents one command, holds it until accepted, then queues the prediction.
    task automatic send_cmd(
        input logic [ACTION_BITS-1:0] act,
        input logic [CNT_W-1:0]       pos,
        input logic [SYM_W-1:0]       sym,
        input logic [KIND_BITS-1:0]   kind
    );
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_action      <= act;
        i_position    <= pos;
        i_symbol_code <= sym;
        i_entry_kind  <= kind;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_results.push_back(predict_outcome(act, pos, sym, kind));
    endtask

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
    endtask

    // Result checker: every strobe must match the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        t_outcome got;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            got.sym    = o_read_symbol;
            got.kind   = o_read_kind;
            got.found  = o_found_position;
            got.status = t_status'(o_status);
            got.count  = o_entry_count;
            if (pending_results.size() == 0) begin
                flag_error("result strobe with no transaction outstanding");
            end else begin
                want = pending_results.pop_front();
                if (got.sym !== want.sym || got.kind !== want.kind ||
                        got.found !== want.found || got.status !== want.status ||
                        got.count !== want.count) begin
                    flag_error({
                        $sformatf("mismatch exp sym=%0d kind=%0d found=%0d st=%0d cnt=%0d",
                            want.sym, want.kind, want.found, want.status, want.count),
                        $sformatf(" | got sym=%0d kind=%0d found=%0d st=%0d cnt=%0d",
                            got.sym, got.kind, got.found, got.status, got.count)});
                end
            end
        end
    end

    // Watchdog: any accepted command or result restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("** gap_buffer_with_group_search_unit: FAILED **");
                $finish;
            end
        end
    end

    // Empty-buffer errors, clamping, spare kind, nested groups, spare actions.
    task automatic test_directed_cases();
        sender_idle_pct = 25;
        send_cmd(ACT_ERASE, '0, '0, KIND_OTHER);
        send_cmd(ACT_READ, '0, '0, KIND_OTHER);
        send_cmd(ACT_DELETE, '0, '0, KIND_OTHER);
        send_cmd(ACT_FIND_END, '0, '0, KIND_OTHER);       // empty: runs off the end
        send_cmd(ACT_FIND_BEGIN, '0, '0, KIND_OTHER);     // empty: runs off the start
        send_cmd(ACT_FIND_END, 11'd1, '0, KIND_OTHER);    // beyond the end
        send_cmd(ACT_FIND_BEGIN, POS_MAX, '0, KIND_OTHER);
        // build B B O O E with clamped and spare-kind inserts
        send_cmd(ACT_INSERT, POS_MAX, 10'h3FF, KIND_BEGIN);
        send_cmd(ACT_INSERT, 11'd1, 10'h000, KIND_OTHER);
        send_cmd(ACT_INSERT, POS_MAX, 10'h155, KIND_SPARE);
        send_cmd(ACT_INSERT, 11'd3, 10'h2AA, KIND_END);
        send_cmd(ACT_INSERT, 11'd1, 10'd5, KIND_BEGIN);
        send_cmd(ACT_FIND_END, 11'd2, '0, KIND_OTHER);    // closes inner group
        send_cmd(ACT_FIND_END, 11'd0, '0, KIND_OTHER);    // outer never closed
        send_cmd(ACT_FIND_END, 11'd5, '0, KIND_OTHER);    // starts at the end
        send_cmd(ACT_FIND_BEGIN, 11'd4, '0, KIND_OTHER);
        send_cmd(ACT_FIND_BEGIN, 11'd5, '0, KIND_OTHER);  // skips a nested pair
        send_cmd(ACT_READ, 11'd0, '0, KIND_OTHER);
        send_cmd(ACT_READ, 11'd3, 10'h3FF, KIND_SPARE);
        send_cmd(ACT_READ, 11'd5, '0, KIND_OTHER);
        send_cmd(ACT_SPARE_6, 11'd2, 10'h3FF, KIND_END);
        send_cmd(ACT_SPARE_7, POS_MAX, 10'h3FF, KIND_SPARE);
        send_cmd(ACT_DELETE, 11'd4, '0, KIND_OTHER);
        send_cmd(ACT_DELETE, 11'd0, '0, KIND_OTHER);
        send_cmd(ACT_ERASE, '0, '0, KIND_OTHER);
    endtask

    function automatic logic [CNT_W-1:0] pick_position(input int n);
        if ($urandom_range(99) < 10) return CNT_W'($urandom_range(2047, n + 1));
        return CNT_W'($urandom_range(n, 0));
    endfunction

    function automatic logic [KIND_BITS-1:0] pick_kind();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)  return KIND_SPARE;
        if (roll < 38) return KIND_BEGIN;
        if (roll < 68) return KIND_END;
        return KIND_OTHER;
    endfunction

    // Random edit/search traffic; the buffer is steered to stay short so gap
    // moves and scans stay cheap. Spare codes do not count toward n_items.
    task automatic test_random_traffic(input int idle_pct, input int n_items);
        int done_items;
        int n;
        int roll;
        int p;
        int inner;
        int k;
        logic [ACTION_BITS-1:0] act;
        sender_idle_pct = idle_pct;
        done_items = 0;
        while (done_items < n_items) begin
            n    = token_seq.size();
            roll = $urandom_range(99);
            if (roll < 10 && n < 40) begin
                // well-formed group: begin, up to three others, end
                p     = $urandom_range(n, 0);
                inner = $urandom_range(3, 0);
                send_cmd(ACT_INSERT, CNT_W'(p), SYM_W'($urandom), KIND_BEGIN);
                for (k = 1; k <= inner; k++)
                    send_cmd(ACT_INSERT, CNT_W'(p + k), SYM_W'($urandom), KIND_OTHER);
                send_cmd(ACT_INSERT, CNT_W'(p + inner + 1), SYM_W'($urandom), KIND_END);
                done_items += inner + 2;
            end else begin
                if (roll < 12) begin
                    act = ($urandom_range(1) != 0) ? ACT_SPARE_6 : ACT_SPARE_7;
                end else if (roll < 14) begin
                    act = ACT_ERASE;
                end else if (roll < ((n < 40) ? 52 : 24)) begin
                    act = ACT_INSERT;
                end else if (roll < 64) begin
                    act = ACT_DELETE;
                end else if (roll < 76) begin
                    act = ACT_READ;
                end else if (roll < 88) begin
                    act = ACT_FIND_END;
                end else begin
                    act = ACT_FIND_BEGIN;
                end
                send_cmd(act, pick_position(n), SYM_W'($urandom), pick_kind());
                if (act != ACT_SPARE_6 && act != ACT_SPARE_7) done_items++;
            end
        end
    endtask

    // Fill to capacity, hit the full case, then run the long moves and scans.
    task automatic test_full_store();
        int k;
        sender_idle_pct = 0;
        send_cmd(ACT_ERASE, '0, '0, KIND_OTHER);
        for (k = 0; k < TOKEN_CAP; k++)
            send_cmd(ACT_INSERT, (k % 7 == 0) ? POS_MAX : CNT_W'(k),
                     SYM_W'($urandom), pick_kind());
        send_cmd(ACT_INSERT, '0, 10'h3FF, KIND_BEGIN);
        send_cmd(ACT_INSERT, POS_MAX, 10'h001, KIND_END);
        send_cmd(ACT_READ, CNT_W'(TOKEN_CAP - 1), '0, KIND_OTHER);
        send_cmd(ACT_READ, CNT_W'(TOKEN_CAP), '0, KIND_OTHER);
        send_cmd(ACT_FIND_END, '0, '0, KIND_OTHER);
        send_cmd(ACT_FIND_END, CNT_W'(TOKEN_CAP), '0, KIND_OTHER);
        send_cmd(ACT_FIND_END, CNT_W'(TOKEN_CAP + 1), '0, KIND_OTHER);
        send_cmd(ACT_FIND_BEGIN, CNT_W'(TOKEN_CAP), '0, KIND_OTHER);
        send_cmd(ACT_DELETE, '0, '0, KIND_OTHER);         // moves the whole gap
        send_cmd(ACT_INSERT, CNT_W'(TOKEN_CAP - 1), 10'h2AA, KIND_END);
        send_cmd(ACT_DELETE, CNT_W'(TOKEN_CAP), '0, KIND_OTHER);
        send_cmd(ACT_DELETE, CNT_W'(TOKEN_CAP - 1), '0, KIND_OTHER);
        send_cmd(ACT_FIND_BEGIN, CNT_W'(TOKEN_CAP - 1), '0, KIND_OTHER);
        send_cmd(ACT_ERASE, '0, '0, KIND_OTHER);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_random_traffic(25, 20);
        test_random_traffic(71, 20);
        test_random_traffic(0, 20);
        test_full_store();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("** gap_buffer_with_group_search_unit: PASSED **");
        end else begin
            $display("** gap_buffer_with_group_search_unit: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
src/gbgs_pkg.sv
src/gbgs_ram.sv
src/gbgs_ctrl.sv
src/gap_buffer_with_group_search_unit.sv
dv/tb_top.sv
